// ===== rtl/core/multichannel_clamped_pid_top_macros.svh =====
// assertion macros shared by the pid controller rtl
`ifndef MULTICHANNEL_CLAMPED_PID_TOP_MACROS_SVH
`define MULTICHANNEL_CLAMPED_PID_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define MCPID_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MCPID_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mcpid_pkg.sv =====
// types, constants and arithmetic helpers of the multichannel pid controller
package mcpid_pkg;

  localparam int CHANNELS  = 16;
  localparam int CH_W      = 4;
  localparam int CH_AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_CMP_W  = ((CH_AW > CH_W) ? CH_AW : CH_W) + 1;
  localparam int DATA_W    = 32;
  localparam int LIM_W     = 31;

  localparam logic OP_STEP = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef enum logic [2:0] {
    COEF_KP   = 3'd0,
    COEF_KI   = 3'd1,
    COEF_KD   = 3'd2,
    COEF_PLIM = 3'd3,
    COEF_ILIM = 3'd4,
    COEF_DLIM = 3'd5,
    COEF_TLIM = 3'd6
  } coef_sel_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] kp;
    logic signed [DATA_W-1:0] ki;
    logic signed [DATA_W-1:0] kd;
    logic [LIM_W-1:0]         p_lim;
    logic [LIM_W-1:0]         i_lim;
    logic [LIM_W-1:0]         d_lim;
    logic [LIM_W-1:0]         t_lim;
  } coef_row_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] integ;
    logic signed [DATA_W-1:0] prev_err;
  } chan_row_t;

  // symmetric clamp of a wide signed value to +/- lim
  function automatic logic signed [DATA_W-1:0] clamp_sym(input logic signed [49:0] v,
                                                         input logic [LIM_W-1:0] lim);
    logic signed [49:0] hi;
    logic signed [49:0] lo;
    logic signed [49:0] r;
    hi = $signed({19'b0, lim});
    lo = -hi;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r[DATA_W-1:0];
  endfunction

  // negative limit words store as zero
  function automatic logic [LIM_W-1:0] limit_word(input logic signed [DATA_W-1:0] v);
    return v[DATA_W-1] ? '0 : v[LIM_W-1:0];
  endfunction

endpackage

// ===== rtl/core/mcpid_if.sv =====
// valid/ready channel interfaces of the pid controller
interface mcpid_in_if import mcpid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [CH_W-1:0]          channel;
  logic signed [DATA_W-1:0] measured;
  logic signed [DATA_W-1:0] setpoint;
  logic [2:0]               coef_select;
  logic signed [DATA_W-1:0] coef_value;

  modport source (
    output valid, opcode, channel, measured, setpoint, coef_select, coef_value,
    input  ready
  );
  modport sink (
    input  valid, opcode, channel, measured, setpoint, coef_select, coef_value,
    output ready
  );
endinterface

interface mcpid_out_if import mcpid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CH_W-1:0]          out_channel;
  logic signed [DATA_W-1:0] drive;

  modport source (
    output valid, out_channel, drive,
    input  ready
  );
  modport sink (
    input  valid, out_channel, drive,
    output ready
  );
endinterface

// ===== rtl/core/mcpid_ram.sv =====
// generic single-write, single-read ram with registered read data
module mcpid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/multichannel_clamped_pid_top.sv =====
// top level of the multichannel clamped pid controller
// Multichannel PID controller in signed Q16.16. Each input transaction is either a
// control step (opcode 0) or a coefficient load (opcode 1) for one channel. Per-channel
// coefficients and limits sit in one ram row, the integrator and previous error in a
// second ram; both have registered read data and are written back by the sequencer,
// so one transaction is in flight at a time. A step reads both rams on acceptance,
// then forms the saturated error and the derivative difference, makes three passes
// through the single shared 32x33 multiplier (kp, ki, kd), clamps the d term, and then
// sums, clamps and loads the output register. A load reads the row, then merges and
// writes it back. An item for a channel at or beyond CHANNELS is taken and dropped.
// Loads give no result. The result waits in an output register, so a new transaction
// can be accepted while the previous drive value is still unclaimed; a step only
// stalls in its last cycle if the output register is still full. Reset clears all
// channel state through per-channel valid bits, with no clearing pass.
`include "multichannel_clamped_pid_top_macros.svh"

module multichannel_clamped_pid_top import mcpid_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  mcpid_in_if.sink     in_i,
  mcpid_out_if.source  out_o
);

  // one-hot sequencer states
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_LOAD   = 8'b0000_0010,
    S_ERR    = 8'b0000_0100,
    S_MUL_P  = 8'b0000_1000,
    S_MUL_I  = 8'b0001_0000,
    S_MUL_D  = 8'b0010_0000,
    S_CLAMPD = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // captured transaction
  logic                     op_q;
  logic [CH_W-1:0]          ch_q;
  logic [CH_AW-1:0]         addr_q;
  logic signed [DATA_W-1:0] meas_q;
  logic signed [DATA_W-1:0] setp_q;
  logic [2:0]               sel_q;
  logic signed [DATA_W-1:0] value_q;

  // per-channel valid bits, an invalid row reads as zero
  logic [CHANNELS-1:0] coef_vld_q;
  logic [CHANNELS-1:0] chan_vld_q;
  logic                coef_rv_q;
  logic                chan_rv_q;

  // datapath registers
  logic signed [DATA_W-1:0] err_q;
  logic signed [DATA_W:0]   diff_q;
  logic signed [64:0]       prod_q;
  logic signed [DATA_W-1:0] p_q;
  logic signed [DATA_W-1:0] i_q;
  logic signed [DATA_W-1:0] d_q;

  // output register
  logic                     out_valid_q;
  logic [CH_W-1:0]          out_ch_q;
  logic signed [DATA_W-1:0] out_drive_q;

  // ram ports
  coef_row_t coef_rdata, coef_cur, coef_wdata;
  chan_row_t chan_rdata, chan_cur, chan_wdata;
  logic      coef_we, chan_we;
  logic      coef_sel_hit;

  // handshake and channel decode
  logic                in_acc;
  logic [CH_CMP_W-1:0] ch_ext;
  logic                in_range;
  logic [CH_AW-1:0]    in_addr;
  logic                out_load;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign ch_ext     = CH_CMP_W'(in_i.channel);
  assign in_range   = ch_ext < CH_CMP_W'(CHANNELS);
  assign in_addr    = ch_ext[CH_AW-1:0];

  // output register is free when empty or being drained this cycle
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  mcpid_ram #(
    .WIDTH ($bits(coef_row_t)),
    .DEPTH (CHANNELS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (coef_we),
    .waddr_i (addr_q),
    .wdata_i (coef_wdata),
    .re_i    (in_acc),
    .raddr_i (in_addr),
    .rdata_o (coef_rdata)
  );

  mcpid_ram #(
    .WIDTH ($bits(chan_row_t)),
    .DEPTH (CHANNELS)
  ) u_chan_ram (
    .clk_i   (clk_i),
    .we_i    (chan_we),
    .waddr_i (addr_q),
    .wdata_i (chan_wdata),
    .re_i    (in_acc),
    .raddr_i (in_addr),
    .rdata_o (chan_rdata)
  );

  // read data stays put until the next transaction is accepted
  assign coef_cur = coef_rv_q ? coef_rdata : '0;
  assign chan_cur = chan_rv_q ? chan_rdata : '0;

  // coefficient merge for loads, select 7 leaves the row alone
  always_comb begin
    coef_wdata   = coef_cur;
    coef_sel_hit = 1'b1;
    case (coef_sel_e'(sel_q))
      COEF_KP:   coef_wdata.kp    = value_q;
      COEF_KI:   coef_wdata.ki    = value_q;
      COEF_KD:   coef_wdata.kd    = value_q;
      COEF_PLIM: coef_wdata.p_lim = limit_word(value_q);
      COEF_ILIM: coef_wdata.i_lim = limit_word(value_q);
      COEF_DLIM: coef_wdata.d_lim = limit_word(value_q);
      COEF_TLIM: coef_wdata.t_lim = limit_word(value_q);
      default:   coef_sel_hit     = 1'b0;
    endcase
  end

  assign coef_we = (state_q == S_LOAD) && coef_sel_hit;

  // channel state write back once the integral term is settled
  assign chan_we          = (state_q == S_CLAMPD);
  assign chan_wdata.integ    = i_q;
  assign chan_wdata.prev_err = err_q;

  // error, saturated to 32 bits, and the exact derivative difference
  logic signed [DATA_W:0]   err_full;
  logic signed [DATA_W-1:0] err_sat;

  always_comb begin
    err_full = {setp_q[DATA_W-1], setp_q} - {meas_q[DATA_W-1], meas_q};
    if (err_full[DATA_W] != err_full[DATA_W-1]) begin
      err_sat = err_full[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      err_sat = err_full[DATA_W-1:0];
    end
  end

  // shared multiplier operand select
  logic signed [DATA_W-1:0] mul_a;
  logic signed [DATA_W:0]   mul_b;

  always_comb begin
    mul_a = coef_cur.kp;
    mul_b = {err_q[DATA_W-1], err_q};
    case (state_q)
      S_MUL_I: mul_a = coef_cur.ki;
      S_MUL_D: begin
        mul_a = coef_cur.kd;
        mul_b = diff_q;
      end
      default: ;
    endcase
  end

  // product floored to Q16.16 and the term sums
  logic signed [48:0] prod_q16;
  logic signed [49:0] integ_sum;
  logic signed [49:0] total_sum;

  assign prod_q16  = prod_q[64:16];
  assign integ_sum = {{18{chan_cur.integ[DATA_W-1]}}, chan_cur.integ}
                   + {prod_q16[48], prod_q16};
  assign total_sum = {{18{p_q[DATA_W-1]}}, p_q}
                   + {{18{i_q[DATA_W-1]}}, i_q}
                   + {{18{d_q[DATA_W-1]}}, d_q};

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && in_range) begin
          state_d = (in_i.opcode == OP_LOAD) ? S_LOAD : S_ERR;
        end
      end
      S_LOAD:   state_d = S_IDLE;
      S_ERR:    state_d = S_MUL_P;
      S_MUL_P:  state_d = S_MUL_I;
      S_MUL_I:  state_d = S_MUL_D;
      S_MUL_D:  state_d = S_CLAMPD;
      S_CLAMPD: state_d = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      coef_vld_q  <= '0;
      chan_vld_q  <= '0;
      coef_rv_q   <= 1'b0;
      chan_rv_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc && in_range) begin
        coef_rv_q <= coef_vld_q[in_addr];
        chan_rv_q <= chan_vld_q[in_addr];
      end
      if (coef_we) begin
        coef_vld_q[addr_q] <= 1'b1;
      end
      if (chan_we) begin
        chan_vld_q[addr_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= in_i.opcode;
      ch_q    <= in_i.channel;
      addr_q  <= in_addr;
      meas_q  <= in_i.measured;
      setp_q  <= in_i.setpoint;
      sel_q   <= in_i.coef_select;
      value_q <= in_i.coef_value;
    end
    if (state_q == S_ERR) begin
      err_q  <= err_sat;
      diff_q <= {err_sat[DATA_W-1], err_sat} - {chan_cur.prev_err[DATA_W-1], chan_cur.prev_err};
    end
    if ((state_q == S_MUL_P) || (state_q == S_MUL_I) || (state_q == S_MUL_D)) begin
      prod_q <= 65'(mul_a) * 65'(mul_b);
    end
    if (state_q == S_MUL_I) begin
      p_q <= clamp_sym({prod_q16[48], prod_q16}, coef_cur.p_lim);
    end
    if (state_q == S_MUL_D) begin
      i_q <= clamp_sym(integ_sum, coef_cur.i_lim);
    end
    if (state_q == S_CLAMPD) begin
      d_q <= clamp_sym({prod_q16[48], prod_q16}, coef_cur.d_lim);
    end
    if (out_load) begin
      out_ch_q    <= ch_q;
      out_drive_q <= clamp_sym(total_sum, coef_cur.t_lim);
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_channel = out_ch_q;
  assign out_o.drive       = out_drive_q;

  // limit checks used by the assertions
  logic signed [DATA_W:0] tlim_ext;
  logic signed [DATA_W:0] ilim_ext;
  logic                   drive_in_lim;
  logic                   integ_in_lim;

  assign tlim_ext     = $signed({2'b0, coef_cur.t_lim});
  assign ilim_ext     = $signed({2'b0, coef_cur.i_lim});
  assign drive_in_lim = ($signed({out_drive_q[DATA_W-1], out_drive_q}) <= tlim_ext)
                     && ($signed({out_drive_q[DATA_W-1], out_drive_q}) >= -tlim_ext);
  assign integ_in_lim = ($signed({i_q[DATA_W-1], i_q}) <= ilim_ext)
                     && ($signed({i_q[DATA_W-1], i_q}) >= -ilim_ext);

  `MCPID_ASSERT_NEXT(a_step_starts, in_acc && in_range && (in_i.opcode == OP_STEP),
    state_q == S_ERR, "accepted step did not start the sequence")
  `MCPID_ASSERT_SAME(a_out_from_done, $rose(out_valid_q), $past(state_q == S_DONE),
    "result appeared outside the final step cycle")
  `MCPID_ASSERT_NEXT(a_drive_clamped, out_load, drive_in_lim,
    "drive exceeds the total limit")
  `MCPID_ASSERT_SAME(a_integ_clamped, chan_we && (op_q == OP_STEP), integ_in_lim,
    "stored integrator exceeds its limit")

endmodule

// ===== test/multichannel_clamped_pid_top_tb.sv =====
// self-checking testbench of the multichannel clamped pid controller
`timescale 1ns / 1ps

module multichannel_clamped_pid_top_tb import mcpid_pkg::*; ();

  // the drain is sized from the length of a step inside the block, to cover any tail
  localparam int STEP_CYCLES  = 7;
  localparam int DRAIN_CYCLES = 4 * STEP_CYCLES;
  localparam int RANDOM_ITEMS = 600;
  localparam int QUIET_FIRST  = 250;
  localparam int QUIET_LAST   = 349;
  localparam int IDLE_PCT     = 20;

  // select code with no coefficient behind it
  localparam logic [2:0] COEF_NONE = 3'd7;

  localparam logic signed [DATA_W-1:0] Q_MAXW = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_MINW = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] Q_ONE  = 32'sh0001_0000;
  localparam logic signed [DATA_W-1:0] Q_FIVE = 32'sh0005_0000;
  localparam logic signed [DATA_W-1:0] Q_NEG1 = 32'shFFFF_FFFF;
  localparam logic signed [DATA_W-1:0] Q_ZERO = 32'sh0000_0000;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  typedef struct packed {
    logic                     opcode;
    logic [CH_W-1:0]          channel;
    logic signed [DATA_W-1:0] measured;
    logic signed [DATA_W-1:0] setpoint;
    logic [2:0]               coef_select;
    logic signed [DATA_W-1:0] coef_value;
  } pid_item_t;

  typedef struct packed {
    logic [CH_W-1:0]          out_channel;
    logic signed [DATA_W-1:0] drive;
  } drive_result_t;

  // one directed row: the item, and a typed-in drive where one is obvious
  typedef struct packed {
    logic                     opcode;
    logic [CH_W-1:0]          channel;
    logic signed [DATA_W-1:0] measured;
    logic signed [DATA_W-1:0] setpoint;
    logic [2:0]               coef_select;
    logic signed [DATA_W-1:0] coef_value;
    logic                     typed;
    logic signed [DATA_W-1:0] typed_drive;
  } directed_row_t;

  localparam int N_DIRECTED = 25;

  directed_row_t directed_rows [N_DIRECTED] = '{
    // fresh channels after reset: all gains and limits are zero
    '{OP_STEP, 4'd0,  Q_ZERO, Q_ZERO, COEF_KP,   Q_ZERO, 1'b1, Q_ZERO},
    // error saturates high, then low
    '{OP_STEP, 4'd15, Q_MINW, Q_MAXW, COEF_KP,   Q_ZERO, 1'b1, Q_ZERO},
    '{OP_STEP, 4'd15, Q_MAXW, Q_MINW, COEF_KP,   Q_ZERO, 1'b1, Q_ZERO},
    // unity proportional gain, wide open p and total limits
    '{OP_LOAD, 4'd3,  Q_ZERO, Q_ZERO, COEF_KP,   Q_ONE,  1'b0, Q_ZERO},
    '{OP_LOAD, 4'd3,  Q_ZERO, Q_ZERO, COEF_PLIM, Q_MAXW, 1'b0, Q_ZERO},
    '{OP_LOAD, 4'd3,  Q_ZERO, Q_ZERO, COEF_TLIM, Q_MAXW, 1'b0, Q_ZERO},
    '{OP_STEP, 4'd3,  Q_ZERO, Q_FIVE, COEF_KP,   Q_ZERO, 1'b1, Q_FIVE},
    // negative limit word stores as zero
    '{OP_LOAD, 4'd3,  Q_ZERO, Q_ZERO, COEF_TLIM, Q_NEG1, 1'b0, Q_ZERO},
    '{OP_STEP, 4'd3,  Q_ZERO, Q_FIVE, COEF_KP,   Q_ZERO, 1'b1, Q_ZERO},
    // unused select leaves the zero total limit alone
    '{OP_LOAD, 4'd3,  Q_ZERO, Q_ZERO, COEF_NONE, Q_MAXW, 1'b0, Q_ZERO},
    '{OP_STEP, 4'd3,  Q_ZERO, Q_FIVE, COEF_KP,   Q_ZERO, 1'b1, Q_ZERO},
    // extreme integral and derivative gains, with the total limit reopened
    '{OP_LOAD, 4'd3,  Q_ZERO, Q_ZERO, COEF_TLIM, Q_MAXW, 1'b0, Q_ZERO},
    '{OP_LOAD, 4'd3,  Q_ZERO, Q_ZERO, COEF_KI,   Q_MAXW, 1'b0, Q_ZERO},
    '{OP_LOAD, 4'd3,  Q_ZERO, Q_ZERO, COEF_ILIM, Q_MAXW, 1'b0, Q_ZERO},
    '{OP_LOAD, 4'd3,  Q_ZERO, Q_ZERO, COEF_KD,   Q_MINW, 1'b0, Q_ZERO},
    '{OP_LOAD, 4'd3,  Q_ZERO, Q_ZERO, COEF_DLIM, Q_MAXW, 1'b0, Q_ZERO},
    // saturated error, then a full 33-bit derivative difference
    '{OP_STEP, 4'd3,  Q_MAXW, Q_MINW, COEF_KP,   Q_ZERO, 1'b0, Q_ZERO},
    '{OP_STEP, 4'd3,  Q_MINW, Q_MAXW, COEF_KP,   Q_ZERO, 1'b0, Q_ZERO},
    // p limit narrowed, negative error to exercise floor truncation
    '{OP_LOAD, 4'd3,  Q_ZERO, Q_ZERO, COEF_PLIM, 32'sh4000_0000, 1'b0, Q_ZERO},
    '{OP_STEP, 4'd3,  32'sh0001_8000, 32'shFFFF_0001, COEF_KP, Q_ZERO, 1'b0, Q_ZERO},
    // most negative proportional gain against a tight total limit
    '{OP_LOAD, 4'd5,  Q_ZERO, Q_ZERO, COEF_KP,   Q_MINW, 1'b0, Q_ZERO},
    '{OP_LOAD, 4'd5,  Q_ZERO, Q_ZERO, COEF_PLIM, Q_MAXW, 1'b0, Q_ZERO},
    '{OP_LOAD, 4'd5,  Q_ZERO, Q_ZERO, COEF_TLIM, 32'sh0000_1000, 1'b0, Q_ZERO},
    '{OP_STEP, 4'd5,  32'sh0000_0003, Q_ZERO, COEF_KP, Q_ZERO, 1'b0, Q_ZERO},
    '{OP_STEP, 4'd3,  32'shFFFE_8000, 32'sh0000_4000, COEF_KP, Q_ZERO, 1'b0, Q_ZERO}
  };

  logic clk_i;
  logic rst_ni;

  mcpid_in_if  in_bus ();
  mcpid_out_if out_bus ();

  multichannel_clamped_pid_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // 20 ns period
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // shadow copy of the per-channel tables and loop state
  logic signed [DATA_W-1:0] kp_tab     [CHANNELS];
  logic signed [DATA_W-1:0] ki_tab     [CHANNELS];
  logic signed [DATA_W-1:0] kd_tab     [CHANNELS];
  logic [LIM_W-1:0]         plim_tab   [CHANNELS];
  logic [LIM_W-1:0]         ilim_tab   [CHANNELS];
  logic [LIM_W-1:0]         dlim_tab   [CHANNELS];
  logic [LIM_W-1:0]         tlim_tab   [CHANNELS];
  logic signed [DATA_W-1:0] integ_acc  [CHANNELS];
  logic signed [DATA_W-1:0] last_error [CHANNELS];

  drive_result_t expected_drives [$];
  int  mismatch_count;
  bit  quiet_stretch;

  // Q16.16 product, floored: arithmetic shift rounds toward minus infinity
  function automatic longint q16_mul(input longint a, input longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic longint clamp_to(input longint v, input logic [LIM_W-1:0] lim);
    longint l;
    l = longint'(lim);
    if (v > l) return l;
    if (v < -l) return -l;
    return v;
  endfunction

  function automatic logic [LIM_W-1:0] nonneg_limit(input logic signed [DATA_W-1:0] v);
    return v[DATA_W-1] ? '0 : v[LIM_W-1:0];
  endfunction

  function automatic void clear_pid_state();
    for (int c = 0; c < CHANNELS; c++) begin
      kp_tab[c]     = '0;
      ki_tab[c]     = '0;
      kd_tab[c]     = '0;
      plim_tab[c]   = '0;
      ilim_tab[c]   = '0;
      dlim_tab[c]   = '0;
      tlim_tab[c]   = '0;
      integ_acc[c]  = '0;
      last_error[c] = '0;
    end
  endfunction

  // applies one item to the shadow state; returns 1 when a drive value comes out
  function automatic bit pid_advance(input pid_item_t it, output drive_result_t res);
    longint err;
    longint p_term;
    longint i_term;
    longint d_term;
    longint total;
    int     ch;
    ch  = int'(it.channel);
    res = '0;
    // a channel beyond the table is dropped; with 16 channels and 4 bits it never is
    if (ch >= CHANNELS) return 1'b0;
    if (it.opcode == OP_LOAD) begin
      case (it.coef_select)
        COEF_KP:   kp_tab[ch]   = it.coef_value;
        COEF_KI:   ki_tab[ch]   = it.coef_value;
        COEF_KD:   kd_tab[ch]   = it.coef_value;
        COEF_PLIM: plim_tab[ch] = nonneg_limit(it.coef_value);
        COEF_ILIM: ilim_tab[ch] = nonneg_limit(it.coef_value);
        COEF_DLIM: dlim_tab[ch] = nonneg_limit(it.coef_value);
        COEF_TLIM: tlim_tab[ch] = nonneg_limit(it.coef_value);
        default: ;
      endcase
      return 1'b0;
    end
    err = longint'($signed(it.setpoint)) - longint'($signed(it.measured));
    if (err > SAT_HI) err = SAT_HI;
    if (err < SAT_LO) err = SAT_LO;
    p_term = clamp_to(q16_mul(longint'(kp_tab[ch]), err), plim_tab[ch]);
    i_term = clamp_to(longint'(integ_acc[ch]) + q16_mul(longint'(ki_tab[ch]), err),
                      ilim_tab[ch]);
    // the derivative difference stays exact, no saturation before the multiply
    d_term = clamp_to(q16_mul(longint'(kd_tab[ch]), err - longint'(last_error[ch])),
                      dlim_tab[ch]);
    total  = clamp_to(p_term + i_term + d_term, tlim_tab[ch]);
    integ_acc[ch]  = i_term[DATA_W-1:0];
    last_error[ch] = err[DATA_W-1:0];
    res.out_channel = it.channel;
    res.drive       = total[DATA_W-1:0];
    return 1'b1;
  endfunction

  // extremes, zero, full-range words and small values around zero
  function automatic logic signed [DATA_W-1:0] pick_word(input int span);
    case ($urandom_range(0, 9))
      0:       return Q_MAXW;
      1:       return Q_MINW;
      2:       return Q_ZERO;
      3, 4:    return $urandom;
      default: return int'($urandom_range(0, 2 * span)) - span;
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_limit();
    case ($urandom_range(0, 9))
      0:          return Q_MAXW;
      1:          return $urandom | 32'h8000_0000;
      2, 3, 4, 5: return $urandom_range(0, 32'h0040_0000);
      default:    return $urandom;
    endcase
  endfunction

  // mostly a few busy channels so integrators and previous errors build up
  function automatic pid_item_t pick_item();
    pid_item_t it;
    it.channel     = ($urandom_range(0, 3) != 0) ? CH_W'($urandom_range(0, 3))
                                                 : CH_W'($urandom_range(0, 15));
    it.opcode      = ($urandom_range(0, 99) < 30) ? OP_LOAD : OP_STEP;
    it.measured    = pick_word(1 << 22);
    it.setpoint    = pick_word(1 << 22);
    it.coef_select = 3'($urandom_range(0, 7));
    if (it.coef_select inside {COEF_KP, COEF_KI, COEF_KD}) begin
      it.coef_value = pick_word(1 << 19);
    end else begin
      it.coef_value = pick_limit();
    end
    return it;
  endfunction

  // presents one transaction, records what it should produce, waits for acceptance
  task automatic send_item(input pid_item_t it, input bit typed,
                           input logic signed [DATA_W-1:0] typed_drive);
    drive_result_t res;
    while (!quiet_stretch && $urandom_range(0, 99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.opcode      <= it.opcode;
    in_bus.channel     <= it.channel;
    in_bus.measured    <= it.measured;
    in_bus.setpoint    <= it.setpoint;
    in_bus.coef_select <= it.coef_select;
    in_bus.coef_value  <= it.coef_value;
    // one transaction in order, so the prediction can be made up front
    if (pid_advance(it, res)) begin
      if (typed) res.drive = typed_drive;
      expected_drives.push_back(res);
    end
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
  endtask

  // result side: random back-pressure and the field-by-field check
  initial begin
    drive_result_t want;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        out_bus.ready <= 1'b0;
      end else begin
        if (out_bus.valid && out_bus.ready) begin
          if (expected_drives.size() == 0) begin
            $error("drive transaction with nothing pending: out_channel %0d drive %0d",
                   out_bus.out_channel, out_bus.drive);
            mismatch_count++;
          end else begin
            want = expected_drives.pop_front();
            if (out_bus.out_channel !== want.out_channel) begin
              $error("out_channel mismatch: expected %0d, actual %0d",
                     want.out_channel, out_bus.out_channel);
              mismatch_count++;
            end
            if (out_bus.drive !== want.drive) begin
              $error("drive mismatch: expected %0d, actual %0d",
                     want.drive, out_bus.drive);
              mismatch_count++;
            end
          end
        end
        out_bus.ready <= quiet_stretch || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // main sequence: reset, directed table, random traffic, drain
  initial begin
    pid_item_t it;
    mismatch_count = 0;
    quiet_stretch  = 1'b0;
    clear_pid_state();
    rst_ni             <= 1'b0;
    in_bus.valid       <= 1'b0;
    in_bus.opcode      <= OP_STEP;
    in_bus.channel     <= '0;
    in_bus.measured    <= '0;
    in_bus.setpoint    <= '0;
    in_bus.coef_select <= COEF_KP;
    in_bus.coef_value  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < N_DIRECTED; r++) begin
      it.opcode      = directed_rows[r].opcode;
      it.channel     = directed_rows[r].channel;
      it.measured    = directed_rows[r].measured;
      it.setpoint    = directed_rows[r].setpoint;
      it.coef_select = directed_rows[r].coef_select;
      it.coef_value  = directed_rows[r].coef_value;
      send_item(it, directed_rows[r].typed, directed_rows[r].typed_drive);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // a stretch where neither side ever idles
      quiet_stretch = (n >= QUIET_FIRST) && (n <= QUIET_LAST);
      send_item(pick_item(), 1'b0, Q_ZERO);
    end
    quiet_stretch = 1'b0;
    in_bus.valid <= 1'b0;

    while (expected_drives.size() != 0) @(posedge clk_i);
    // a trailing load may still be in flight; also catches any stray drive
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
